/* rtl/fixed_frame_resync_checker_core_assert.svh */
// Assertion macros for the frame resync checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef FIXED_FRAME_RESYNC_CHECKER_CORE_ASSERT_SVH
`define FIXED_FRAME_RESYNC_CHECKER_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define FFRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FFRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/ffrc_pkg.sv */
// Shared types and constants of the frame resync checker.
// No dependencies.
package ffrc_pkg;

    localparam int FrameBytes = 13;
    localparam int WinBytes   = FrameBytes - 1;
    localparam int SumBytes   = FrameBytes - 2;
    localparam int DataBytes  = 9;
    localparam int DataFirst  = 2;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_fill;
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEAD_FIRST  = 2'd0;
    localparam t_cfg_idx CFG_HEAD_SECOND = 2'd1;
    localparam t_cfg_idx CFG_TAIL_VALUE  = 2'd2;

endpackage

/* rtl/fixed_frame_resync_checker_core.sv */
// Frame resync checker: 13-byte window, header/tail/checksum check, resync.
// Depends on ffrc_pkg.
//
// Usage:
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received byte
//   per transaction. When the 13th byte of a window arrives the frame is
//   checked; a passing frame yields one transaction on the result channel
//   (o_res_valid / i_res_ready / o_data_0..o_data_8, frame bytes 2..10).
//   A failing frame realigns the window on the next head_first byte.
//   cfg channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) writes
//   head_first (0), head_second (1), tail_value (2); index 3 is ignored.
//   o_cfg_ready is always high.
// Timing:
//   One byte per cycle sustained while no result is stalled. A result is valid
//   the cycle after the byte that completes the frame; the check, checksum
//   and resync shift are all combinational, fed by the window registers.
// Reset: window empties, result valid clears, config registers go to zero.
// Stall: while a result waits, bytes that do not complete a frame are still
//   taken; o_rx_ready drops only when the next byte would complete one.
module fixed_frame_resync_checker_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  ffrc_pkg::t_cfg_idx i_cfg_index,
    input  ffrc_pkg::t_byte  i_cfg_data,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  ffrc_pkg::t_byte  i_rx_byte,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output ffrc_pkg::t_byte  o_data_0,
    output ffrc_pkg::t_byte  o_data_1,
    output ffrc_pkg::t_byte  o_data_2,
    output ffrc_pkg::t_byte  o_data_3,
    output ffrc_pkg::t_byte  o_data_4,
    output ffrc_pkg::t_byte  o_data_5,
    output ffrc_pkg::t_byte  o_data_6,
    output ffrc_pkg::t_byte  o_data_7,
    output ffrc_pkg::t_byte  o_data_8
);
    import ffrc_pkg::*;

    t_byte r_head_first;
    t_byte r_head_second;
    t_byte r_tail_value;
    t_fill r_fill;
    logic  r_res_valid;
    t_byte r_win  [WinBytes];
    t_byte r_data [DataBytes];

    t_byte frame  [FrameBytes];
    t_byte n_win  [WinBytes];
    t_byte pair   [SumBytes / 2];
    t_byte sum;
    logic  frame_ok;
    logic  found;
    t_fill shift;
    logic  [4:0] src;
    logic  full;
    logic  rx_acc;

    assign full        = (r_fill == t_fill'(WinBytes));
    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !full || !r_res_valid || i_res_ready;
    assign rx_acc      = i_rx_valid && o_rx_ready;
    assign o_res_valid = r_res_valid;

    always_comb begin
        for (int i = 0; i < WinBytes; i++) begin
            frame[i] = r_win[i];
        end
        frame[WinBytes] = i_rx_byte;

        for (int i = 0; i < SumBytes / 2; i++) begin
            pair[i] = frame[2 * i] + frame[2 * i + 1];
        end
        sum = frame[SumBytes - 1];
        for (int i = 0; i < SumBytes / 2; i++) begin
            sum = sum + pair[i];
        end

        frame_ok = (frame[0] == r_head_first) && (frame[1] == r_head_second)
                && (frame[FrameBytes - 1] == r_tail_value)
                && (frame[FrameBytes - 2] == sum);

        found = 1'b0;
        shift = '0;
        for (int k = FrameBytes - 1; k >= 1; k--) begin
            if (frame[k] == r_head_first) begin
                found = 1'b1;
                shift = t_fill'(k);
            end
        end

        for (int i = 0; i < WinBytes; i++) begin
            src = 5'(i) + {1'b0, shift};
            if (src <= 5'(FrameBytes - 1)) begin
                n_win[i] = frame[src[3:0]];
            end else begin
                n_win[i] = r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_res_valid   <= 1'b0;
            r_head_first  <= '0;
            r_head_second <= '0;
            r_tail_value  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                    CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                    CFG_TAIL_VALUE:  r_tail_value  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (rx_acc && full && frame_ok) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (rx_acc) begin
                if (!full) begin
                    r_fill <= r_fill + 4'd1;
                end else if (frame_ok) begin
                    r_fill <= '0;
                end else if (found) begin
                    r_fill <= t_fill'(FrameBytes) - shift;
                end else begin
                    r_fill <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            if (!full) begin
                r_win[r_fill] <= i_rx_byte;
            end else if (frame_ok) begin
                for (int j = 0; j < DataBytes; j++) begin
                    r_data[j] <= frame[DataFirst + j];
                end
            end else if (found) begin
                r_win <= n_win;
            end
        end
    end

    assign o_data_0 = r_data[0];
    assign o_data_1 = r_data[1];
    assign o_data_2 = r_data[2];
    assign o_data_3 = r_data[3];
    assign o_data_4 = r_data[4];
    assign o_data_5 = r_data[5];
    assign o_data_6 = r_data[6];
    assign o_data_7 = r_data[7];
    assign o_data_8 = r_data[8];

endmodule

/* rtl/ffrc_assert_checker.sv */
// Port-level assertions for the frame resync checker, bound to fixed_frame_resync_checker_core.
// Depends on ffrc_pkg and fixed_frame_resync_checker_core_assert.svh.
`include "fixed_frame_resync_checker_core_assert.svh"

module ffrc_assert_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rx_valid,
    input logic               o_rx_ready,
    input logic               o_res_valid,
    input logic               i_res_ready,
    input ffrc_pkg::t_byte    o_data_0,
    input ffrc_pkg::t_byte    o_data_1,
    input ffrc_pkg::t_byte    o_data_2,
    input ffrc_pkg::t_byte    o_data_3,
    input ffrc_pkg::t_byte    o_data_4,
    input ffrc_pkg::t_byte    o_data_5,
    input ffrc_pkg::t_byte    o_data_6,
    input ffrc_pkg::t_byte    o_data_7,
    input ffrc_pkg::t_byte    o_data_8
);
    import ffrc_pkg::*;

    logic                     rx_acc;
    logic                     res_acc;
    logic                     res_stall;
    logic [8*DataBytes-1:0]   res_bus;

    assign rx_acc    = i_rx_valid && o_rx_ready;
    assign res_acc   = o_res_valid && i_res_ready;
    assign res_stall = o_res_valid && !i_res_ready;
    assign res_bus   = {o_data_8, o_data_7, o_data_6, o_data_5, o_data_4,
                        o_data_3, o_data_2, o_data_1, o_data_0};

    `FFRC_ASSERT(a_res_hold, res_stall |=> o_res_valid && $stable(res_bus), "result not held")

    `FFRC_ASSERT(a_res_needs_rx, $rose(o_res_valid) |-> $past(rx_acc), "result without input")

    `FFRC_ASSERT(a_rx_stall_cause, !o_rx_ready |-> res_stall, "rx stall without pending result")

    `FFRC_ASSERT(a_res_drain, res_acc && !rx_acc |=> !o_res_valid, "result repeated")

endmodule

bind fixed_frame_resync_checker_core ffrc_assert_checker u_ffrc_assert_checker (.*);

/* verif/tb.sv */
// Testbench for fixed_frame_resync_checker_core: frame check, resync and result stream.
// Depends on ffrc_pkg and the core RTL. Expected frames come from a scoreboard class that
// tracks the byte window and registers; both channels idle and stall at random.
`timescale 1ns / 100ps

module tb;
    import ffrc_pkg::*;

    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef logic [DataBytes-1:0][7:0] t_payload;

    class frame_scoreboard;
        t_byte    win_bytes [FrameBytes];
        int       win_level;
        t_byte    sync_a;
        t_byte    sync_b;
        t_byte    end_mark;
        t_payload pending [$];
        int       errors;

        function new();
            win_level = 0;
            sync_a    = '0;
            sync_b    = '0;
            end_mark  = '0;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_byte val);
            case (idx)
                CFG_HEAD_FIRST:  sync_a   = val;
                CFG_HEAD_SECOND: sync_b   = val;
                CFG_TAIL_VALUE:  end_mark = val;
                default: ;
            endcase
        endfunction

        // Window update for one accepted byte.
        function void note_byte(t_byte b);
            t_byte    sum;
            t_payload frame;
            bit       found;
            if (win_level >= FrameBytes) win_level = 0;
            win_bytes[win_level] = b;
            win_level++;
            if (win_level < FrameBytes) return;
            sum = '0;
            for (int i = 0; i < SumBytes; i++) sum = sum + win_bytes[i];
            if (win_bytes[0] == sync_a && win_bytes[1] == sync_b &&
                win_bytes[FrameBytes-1] == end_mark && win_bytes[SumBytes] == sum) begin
                for (int j = 0; j < DataBytes; j++) frame[j] = win_bytes[DataFirst+j];
                pending.push_back(frame);
                win_level = 0;
                return;
            end
            found = 0;
            for (int k = 1; k < FrameBytes; k++) begin
                if (!found && win_bytes[k] == sync_a) begin
                    for (int i = 0; i < FrameBytes - k; i++) win_bytes[i] = win_bytes[i+k];
                    win_level = FrameBytes - k;
                    found = 1;
                end
            end
            if (!found) win_level = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_frame(t_payload got);
            t_payload exp_frame;
            if (pending.size() == 0) begin
                report("result transaction with no frame pending");
                return;
            end
            exp_frame = pending.pop_front();
            for (int j = 0; j < DataBytes; j++)
                if (got[j] !== exp_frame[j])
                    report($sformatf("data_%0d got %02h expected %02h", j, got[j], exp_frame[j]));
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_byte    i_cfg_data;
    logic     i_rx_valid;
    logic     o_rx_ready;
    t_byte    i_rx_byte;
    logic     o_res_valid;
    logic     i_res_ready;
    t_byte    o_data_0, o_data_1, o_data_2, o_data_3, o_data_4;
    t_byte    o_data_5, o_data_6, o_data_7, o_data_8;

    frame_scoreboard sb = new();
    bit no_gaps;
    bit hold_off_req;

    fixed_frame_resync_checker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_data_0    (o_data_0),
        .o_data_1    (o_data_1),
        .o_data_2    (o_data_2),
        .o_data_3    (o_data_3),
        .o_data_4    (o_data_4),
        .o_data_5    (o_data_5),
        .o_data_6    (o_data_6),
        .o_data_7    (o_data_7),
        .o_data_8    (o_data_8)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input t_byte b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_byte(b);
    endtask

    // fixed < 0 gives random data bytes, otherwise all data bytes take that value.
    task automatic send_frame(input bit corrupt, input int keep, input int fixed);
        t_byte fr [FrameBytes];
        t_byte sum;
        int    pos;
        fr[0] = sb.sync_a;
        fr[1] = sb.sync_b;
        for (int j = 0; j < DataBytes; j++) begin
            if (fixed >= 0) fr[DataFirst+j] = t_byte'(fixed);
            else if ($urandom_range(0, 3) == 0) fr[DataFirst+j] = sb.sync_a;
            else fr[DataFirst+j] = t_byte'($urandom_range(0, 255));
        end
        sum = '0;
        for (int i = 0; i < SumBytes; i++) sum = sum + fr[i];
        fr[SumBytes]     = sum;
        fr[FrameBytes-1] = sb.end_mark;
        if (corrupt) begin
            pos = $urandom_range(0, FrameBytes - 1);
            fr[pos] = fr[pos] ^ t_byte'($urandom_range(1, 255));
        end
        for (int i = 0; i < keep; i++) send_byte(fr[i]);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input t_byte val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input t_byte a, input t_byte b, input t_byte c);
        drain();
        cfg_write(CFG_HEAD_FIRST, a);
        cfg_write(CFG_HEAD_SECOND, b);
        cfg_write(CFG_TAIL_VALUE, c);
    endtask

    task automatic run_phase(input int frames);
        int r;
        for (int n = 0; n < frames; n++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_frame(1'b0, FrameBytes, -1);
            end else if (r < 77) begin
                send_frame(1'b1, FrameBytes, -1);
            end else if (r < 89) begin
                repeat ($urandom_range(1, 5))
                    send_byte(($urandom_range(0, 4) == 0) ? sb.sync_a
                                                          : t_byte'($urandom_range(0, 255)));
            end else begin
                send_frame(1'b0, $urandom_range(1, FrameBytes - 1), -1);
            end
        end
        i_rx_valid <= 1'b0;
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_frame({o_data_8, o_data_7, o_data_6, o_data_5, o_data_4,
                            o_data_3, o_data_2, o_data_1, o_data_0});
    end

    // Result sink: random stalls, ready-high runs, and one long hold on request.
    initial begin
        int gap;
        i_res_ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_res_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HEAD_FIRST;
        i_cfg_data  <= '0;
        i_rx_valid  <= 1'b0;
        i_rx_byte   <= '0;
        no_gaps      = 0;
        hold_off_req = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: all zero. Spare index must be ignored.
        cfg_write(CFG_SPARE, 8'hFF);
        send_frame(1'b0, FrameBytes, 255);
        send_frame(1'b1, FrameBytes, 0);
        i_rx_valid <= 1'b0;

        apply_config(8'hFF, 8'hFF, 8'hFF);
        hold_off_req = 1;
        run_phase(24);
        apply_config(8'hA5, 8'h5A, 8'h0F);
        no_gaps = 1;
        run_phase(24);
        no_gaps = 0;
        apply_config(8'h00, 8'hFF, 8'h00);
        run_phase(24);
        apply_config(8'h7E, 8'h7E, 8'h7E);
        run_phase(24);
        for (int p = 0; p < 3; p++) begin
            apply_config(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                         t_byte'($urandom_range(0, 255)));
            run_phase(24);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ffrc_pkg.sv
rtl/fixed_frame_resync_checker_core.sv
rtl/ffrc_assert_checker.sv
verif/tb.sv
